/* rtl/lru_key_value_cache_core_assert.svh */
// Assertion macros for the LRU key/value cache core.
// Included by the top level; needs nothing else.
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LKC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("cache core check failed");
// Next-cycle implication, checked out of reset.
`define LKC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("cache core check failed");
`else
`define LKC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LKC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/lrukv_pkg.sv */
// Shared widths, operation codes and control struct for the LRU cache core.
// No dependencies.
package lrukv_pkg;

	localparam int KEY_W = 64;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	// Decisions the lookup hands to the state update.
	typedef struct packed {
		logic found;   // key present before this request
		logic put;     // request is a put
		logic touch;   // move the target entry to most recent
		logic insert;  // write the key into the target entry
		logic alloc;   // target entry was free and becomes valid
	} lookup_ctrl_t;

endpackage

/* rtl/lrukv_lookup.sv */
// Parallel key match and target selection for the LRU cache core.
// Depends on lrukv_pkg.
module lrukv_lookup #(
	parameter int ENTRIES = 16,
	parameter int RW = $clog2(ENTRIES),
	parameter int CW = $clog2(ENTRIES + 1)
) (
	input  logic [ENTRIES-1:0]          valid_v,
	input  logic [lrukv_pkg::KEY_W-1:0] key_arr [ENTRIES],
	input  logic [lrukv_pkg::VAL_W-1:0] value_arr [ENTRIES],
	input  logic [RW-1:0]               rank_arr [ENTRIES],
	input  logic [CW-1:0]               count,
	input  logic                        full,
	input  logic                        kind,
	input  logic [lrukv_pkg::KEY_W-1:0] key,
	output logic [ENTRIES-1:0]          match,
	output logic [ENTRIES-1:0]          target_oh,
	output logic [CW-1:0]               old_rank,
	output logic [lrukv_pkg::VAL_W-1:0] read_value,
	output lrukv_pkg::lookup_ctrl_t     ctrl
);
	import lrukv_pkg::*;

	logic [ENTRIES-1:0] victim;
	logic [ENTRIES-1:0] free_oh;
	logic [ENTRIES-1:0] invalid;
	logic [RW-1:0]      hit_rank;
	logic [VAL_W-1:0]   hit_value;
	logic [CW-1:0]      last_rank;

	assign invalid   = ~valid_v;
	// lowest free slot as a one-hot
	assign free_oh   = invalid & (~invalid + ENTRIES'(1));
	assign last_rank = count - CW'(1);

	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_v[i] && (key_arr[i] == key);
			// valid ranks form 0..count-1, so the oldest holds count-1
			victim[i] = valid_v[i] && (CW'(rank_arr[i]) == last_rank);
			hit_rank  = hit_rank | (match[i] ? rank_arr[i] : '0);
			hit_value = hit_value | (match[i] ? value_arr[i] : '0);
		end
	end

	always_comb begin
		ctrl.found  = |match;
		ctrl.put    = (kind == KIND_PUT);
		ctrl.touch  = ctrl.found || ctrl.put;
		ctrl.insert = !ctrl.found && ctrl.put;
		ctrl.alloc  = ctrl.insert && !full;
		if (ctrl.found) begin
			target_oh = match;
			old_rank  = CW'(hit_rank);
		end else if (full) begin
			target_oh = victim;
			old_rank  = last_rank;
		end else begin
			target_oh = free_oh;
			old_rank  = count;
		end
		read_value = (ctrl.found && !ctrl.put) ? hit_value : '0;
	end

endmodule

/* rtl/lrukv_rank.sv */
// Recency rank update for the LRU cache core: on a touch the target goes to rank 0,
// more recent valid entries age by one. Depends on lrukv_pkg.
module lrukv_rank #(
	parameter int ENTRIES = 16,
	parameter int RW = $clog2(ENTRIES),
	parameter int CW = $clog2(ENTRIES + 1)
) (
	input  logic [ENTRIES-1:0]      valid_v,
	input  logic [RW-1:0]           rank_arr [ENTRIES],
	input  logic [ENTRIES-1:0]      target_oh,
	input  logic [CW-1:0]           old_rank,
	input  lrukv_pkg::lookup_ctrl_t ctrl,
	output logic [RW-1:0]           rank_nxt [ENTRIES]
);
	import lrukv_pkg::*;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (ctrl.touch && target_oh[i]) begin
				rank_nxt[i] = '0;
			end else if (ctrl.touch && valid_v[i] && (CW'(rank_arr[i]) < old_rank)) begin
				rank_nxt[i] = rank_arr[i] + RW'(1);
			end else begin
				rank_nxt[i] = rank_arr[i];
			end
		end
	end

endmodule

/* rtl/lru_key_value_cache_core.sv */
// Top level of the fully associative LRU key/value cache core.
// Depends on lrukv_pkg, lrukv_lookup, lrukv_rank and the assertion header.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   kind, key, value
//   rsp      out        rsp_valid/rsp_stall   hit, read_value
//   cfg      in         cfg_we                cfg_wdata (capacity)
//
// One request per cycle sustained while the response side does not stall. Response
// valid rises once the request beat has passed the request register, then the lookup
// and state update into the response register. The whole key compare and rank update
// sit between those two registers. Reset clears all valid marks, ranks, the entry
// count and sets the capacity to 16; no clearing pass. A stalled response holds the
// stage, and the request side stalls only while a request waits behind it.
`include "lru_key_value_cache_core_assert.svh"

module lru_key_value_cache_core #(
	parameter int ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        kind,
	input  logic [lrukv_pkg::KEY_W-1:0] key,
	input  logic [lrukv_pkg::VAL_W-1:0] value,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        hit,
	output logic [lrukv_pkg::VAL_W-1:0] read_value,
	input  logic                        cfg_we,
	input  logic [lrukv_pkg::CAP_W-1:0] cfg_wdata
);
	import lrukv_pkg::*;

	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	// request stage
	logic             valid_s1;
	logic             kind_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] value_s1;

	// response stage
	logic             valid_s2;
	logic             hit_s2;
	logic [VAL_W-1:0] read_value_s2;

	// cache state
	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q [ENTRIES];
	logic [VAL_W-1:0]   value_q [ENTRIES];
	logic [RW-1:0]      rank_q [ENTRIES];
	logic [CW-1:0]      count_q;
	logic [CAP_W-1:0]   capacity_q;

	logic               fire;
	logic               req_beat;
	logic [EW-1:0]      cap_ext;
	logic [EW-1:0]      eff_cap;
	logic               full;
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] target_oh;
	logic [CW-1:0]      old_rank;
	logic [VAL_W-1:0]   lookup_value;
	lookup_ctrl_t       ctrl;
	logic [RW-1:0]      rank_nxt [ENTRIES];

	// Advance the request stage whenever the response register is free or drains.
	assign fire      = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !fire;
	assign req_beat  = req_valid && !req_stall;

	assign rsp_valid  = valid_s2;
	assign hit        = hit_s2;
	assign read_value = read_value_s2;

	// Saturate the capacity register to 1..ENTRIES.
	assign cap_ext = EW'(capacity_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(ENTRIES)) begin
			eff_cap = EW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign full = (EW'(count_q) >= eff_cap);

	lrukv_lookup #(
		.ENTRIES (ENTRIES),
		.RW      (RW),
		.CW      (CW)
	) u_lookup (
		.valid_v    (valid_q),
		.key_arr    (key_q),
		.value_arr  (value_q),
		.rank_arr   (rank_q),
		.count      (count_q),
		.full       (full),
		.kind       (kind_s1),
		.key        (key_s1),
		.match      (match),
		.target_oh  (target_oh),
		.old_rank   (old_rank),
		.read_value (lookup_value),
		.ctrl       (ctrl)
	);

	lrukv_rank #(
		.ENTRIES (ENTRIES),
		.RW      (RW),
		.CW      (CW)
	) u_rank (
		.valid_v   (valid_q),
		.rank_arr  (rank_q),
		.target_oh (target_oh),
		.old_rank  (old_rank),
		.ctrl      (ctrl),
		.rank_nxt  (rank_nxt)
	);

	// Request register: take a beat whenever the stage is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_beat) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_beat) begin
			kind_s1  <= kind;
			key_s1   <= key;
			value_s1 <= value;
		end
	end

	// Response register: hold while stalled, drop after the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_s2        <= ctrl.found;
			read_value_s2 <= lookup_value;
		end
	end

	// Capacity only changes while the cache holds nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we && (count_q == '0)) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Valid marks, ranks and fill count: cleared by reset, updated per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (fire) begin
			if (ctrl.alloc) begin
				valid_q <= valid_q | target_oh;
				count_q <= count_q + CW'(1);
			end
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_nxt[i];
			end
		end
	end

	// Key and value storage: written only into the target entry.
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (fire && ctrl.insert && target_oh[i]) begin
				key_q[i] <= key_s1;
			end
			if (fire && ctrl.put && target_oh[i]) begin
				value_q[i] <= value_s1;
			end
		end
	end

	// Fill count tracks the valid marks.
	`LKC_ASSERT_IMP(a_count_matches_valid, clk, arst_n, 1'b1, $countones(valid_q) == count_q)
	// Keys stay unique, so at most one entry matches.
	`LKC_ASSERT_IMP(a_single_match, clk, arst_n, fire, $onehot0(match))
	// An allocation grows the fill count by exactly one.
	`LKC_ASSERT_NXT(a_alloc_count, clk, arst_n, fire && ctrl.alloc, count_q == $past(count_q) + CW'(1))
	// Capacity holds while the cache is not empty.
	`LKC_ASSERT_NXT(a_cap_locked, clk, arst_n, cfg_we && (count_q != '0), $stable(capacity_q))

endmodule

/* test/lrukv_tb_pkg.sv */
// Scoreboard for the LRU key/value cache core testbench: a mirror of the
// cache state that predicts each response and checks the observed ones.
// Depends on lrukv_pkg for widths, operation codes and the capacity reset.
package lrukv_tb_pkg;

	import lrukv_pkg::*;

	localparam int CACHE_SLOTS = 16;
	localparam int RANK_W = $clog2(CACHE_SLOTS);

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
	} cache_rsp_t;

	class cache_scoreboard;
		bit               slot_valid[CACHE_SLOTS];
		logic [KEY_W-1:0] slot_key[CACHE_SLOTS];
		logic [VAL_W-1:0] slot_value[CACHE_SLOTS];
		logic [RANK_W-1:0] slot_rank[CACHE_SLOTS];
		int unsigned      live_count;
		logic [CAP_W-1:0] capacity;
		cache_rsp_t       expected_rsp[$];
		int               errors, gets, puts, hits, evictions, checked;

		function new();
			capacity = CAP_RESET;
			live_count = 0;
			foreach (slot_valid[i]) begin
				slot_valid[i] = 1'b0;
				slot_rank[i] = '0;
			end
		endfunction

		// Register value saturated into 1..CACHE_SLOTS.
		function int unsigned cap_limit();
			if (capacity == 0)
				return 1;
			if (capacity > CACHE_SLOTS)
				return CACHE_SLOTS;
			return capacity;
		endfunction

		function void write_capacity(logic [CAP_W-1:0] w);
			if (live_count == 0)
				capacity = w;
		endfunction

		// Make slot s most recent; valid entries newer than old_rank age by one.
		function void promote(int s, int old_rank);
			foreach (slot_valid[i]) begin
				if (slot_valid[i] && i != s && int'(slot_rank[i]) < old_rank)
					slot_rank[i] = slot_rank[i] + 1'b1;
			end
			slot_rank[s] = '0;
		endfunction

		function void note_request(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
			cache_rsp_t rsp;
			int         slot;
			int         worst;
			bit         found;
			found = 1'b0;
			slot = 0;
			for (int i = 0; i < CACHE_SLOTS; i++) begin
				if (!found && slot_valid[i] && slot_key[i] == k) begin
					slot = i;
					found = 1'b1;
				end
			end
			rsp.hit = found;
			rsp.read_value = '0;
			if (op == KIND_GET)
				gets++;
			else
				puts++;
			if (found) begin
				hits++;
				if (op == KIND_GET)
					rsp.read_value = slot_value[slot];
				else
					slot_value[slot] = v;
				promote(slot, int'(slot_rank[slot]));
			end else if (op == KIND_PUT) begin
				if (live_count >= cap_limit()) begin
					// Replace the least recent entry in place.
					worst = -1;
					foreach (slot_valid[i]) begin
						if (slot_valid[i] && int'(slot_rank[i]) > worst) begin
							worst = int'(slot_rank[i]);
							slot = i;
						end
					end
					slot_key[slot] = k;
					slot_value[slot] = v;
					promote(slot, worst);
					evictions++;
				end else begin
					// Take the lowest free slot.
					slot = -1;
					foreach (slot_valid[i]) begin
						if (slot < 0 && !slot_valid[i])
							slot = i;
					end
					slot_valid[slot] = 1'b1;
					slot_key[slot] = k;
					slot_value[slot] = v;
					promote(slot, int'(live_count));
					live_count++;
				end
			end
			expected_rsp.push_back(rsp);
		endfunction

		task report(string what);
			$display("cache mismatch: %s", what);
			errors++;
		endtask

		task check_response(logic hit, logic [VAL_W-1:0] rv);
			cache_rsp_t exp_rsp;
			if (expected_rsp.size() == 0) begin
				report($sformatf("response hit=%0b value=%h with nothing outstanding", hit, rv));
				return;
			end
			exp_rsp = expected_rsp.pop_front();
			checked++;
			if (hit !== exp_rsp.hit)
				report($sformatf("response %0d hit=%0b, predicted %0b",
					checked, hit, exp_rsp.hit));
			if (rv !== exp_rsp.read_value)
				report($sformatf("response %0d read_value=%h, predicted %h",
					checked, rv, exp_rsp.read_value));
		endtask

		task flush_leftovers();
			if (expected_rsp.size() != 0)
				report($sformatf("%0d responses never arrived", expected_rsp.size()));
			expected_rsp.delete();
		endtask
	endclass

endpackage

/* test/tb.sv */
// Top-level testbench for lru_key_value_cache_core: directed and random get/put
// traffic with random request gaps and response stalls, checked by cache_scoreboard.
// Depends on lrukv_pkg, lrukv_tb_pkg and the cache core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lrukv_pkg::*;
	import lrukv_tb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASES      = 3;
	localparam int PHASE_ITEMS = 650;
	localparam int POOL_MAX    = 24;
	localparam int DRAIN       = 6;    // margin after the last predicted response

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             kind = KIND_GET;
	logic [KEY_W-1:0] key = '0;
	logic [VAL_W-1:0] value = '0;
	logic             rsp_stall = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic             req_stall;
	logic             rsp_valid;
	logic             hit;
	logic [VAL_W-1:0] read_value;

	cache_scoreboard sb = new();

	int unsigned cycles = 0;
	int unsigned input_stalls = 0;
	int          hold_asks = 0;    // bumped by the stimulus to request a long hold-off
	int          hold_done = 0;
	int          hold_left = 0;
	int          run_left = 0;
	bit          run_stall = 1'b0;
	bit          tx_quiet = 1'b0;

	always #4 clk = ~clk;

	lru_key_value_cache_core #(
		.ENTRIES(CACHE_SLOTS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.key       (key),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.hit       (hit),
		.read_value(read_value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Hard stop: no correct run gets anywhere near this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (req_valid && req_stall)
			input_stalls <= input_stalls + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, sb.expected_rsp.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Check every response beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(hit, read_value);
	end

	// Response-side back-pressure. Serve a pending long hold-off first, otherwise
	// run alternating stretches of stall and flow with random lengths.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (hold_done != hold_asks) begin
			hold_done = hold_asks;
			hold_left = LONG_HOLD - 1;
			rsp_stall <= 1'b1;
		end else begin
			if (run_left == 0) begin
				case ($urandom_range(0, 19))
					0, 1: begin
						run_stall = 1'b0;
						run_left = $urandom_range(50, 150);
					end
					2: begin
						run_stall = 1'b1;
						run_left = $urandom_range(8, 40);
					end
					3, 4, 5, 6, 7, 8: begin
						run_stall = 1'b1;
						run_left = $urandom_range(1, 3);
					end
					default: begin
						run_stall = 1'b0;
						run_left = $urandom_range(1, 20);
					end
				endcase
			end
			run_left = run_left - 1;
			rsp_stall <= run_stall;
		end
	end

	// Sender gap: mostly none or short, now and then long; none in quiet stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		return {$urandom, $urandom};
	endfunction

	// Offer one request beat starting at a falling edge and hold it until taken.
	// Returns on the falling edge after acceptance with valid still high.
	task automatic send_request(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v, int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		kind <= op;
		key <= k;
		value <= v;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(op, k, v);
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted response has come back.
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.expected_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// Write the capacity register; call only while idle, on a falling edge.
	task automatic write_capacity(logic [CAP_W-1:0] w);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		sb.write_capacity(w);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [KEY_W-1:0] key_pool[POOL_MAX];
		logic [KEY_W-1:0] k;
		logic [CAP_W-1:0] cap_sel;
		logic             op;
		int               pool_n;
		int               cap_eff;
		int               r;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// While empty the register takes every write: try both out-of-range
		// ends with lookups only, since any put would lock the setting in.
		write_capacity('0);
		send_request(KIND_GET, '0, '1, 0);
		send_request(KIND_GET, '1, 32'h8000_0001, 1);
		settle();
		write_capacity('1);
		send_request(KIND_GET, 64'h8000_0000_0000_0001, '0, 0);
		settle();

		// Pick the working capacity; saturating encodings and the full size
		// come up often so both ends see put traffic across seeds.
		r = $urandom_range(0, 9);
		case (r)
			0:       cap_sel = '0;
			1:       cap_sel = '1;
			2, 3, 4: cap_sel = CAP_W'(CACHE_SLOTS);
			default: cap_sel = CAP_W'($urandom_range(2, CACHE_SLOTS - 1));
		endcase
		write_capacity(cap_sel);
		cap_eff = sb.cap_limit();

		// Directed: extreme keys and values, hit on get, update on put, then
		// fill past capacity so the oldest key is evicted and missed.
		send_request(KIND_PUT, '0, '0, 0);
		send_request(KIND_PUT, '1, '1, 0);
		send_request(KIND_GET, '0, '1, 0);
		send_request(KIND_GET, '1, '0, 2);
		send_request(KIND_PUT, '1, 32'h5A5A_0001, 0);
		send_request(KIND_GET, '1, 32'hFFFF_0000, 0);
		for (int i = 0; i < cap_eff; i++)
			send_request(KIND_PUT, fresh_key(), $urandom, 0);
		send_request(KIND_GET, '0, '0, 0);

		// Random traffic over a key pool a bit larger than the capacity, so
		// hits, updates and evictions all stay frequent.
		pool_n = cap_eff + 4 + $urandom_range(0, cap_eff);
		if (pool_n > POOL_MAX)
			pool_n = POOL_MAX;
		foreach (key_pool[i])
			key_pool[i] = fresh_key();
		key_pool[0] = '0;
		key_pool[1] = '1;

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				// Cache is no longer empty here; these writes must not take.
				settle();
				write_capacity(ph == 1 ? '0 : '1);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 64 == 0)
					tx_quiet = ($urandom_range(0, 3) == 0);
				// Hold off the receiver while traffic keeps coming.
				if (ph == 1 && n == 50)
					hold_asks = hold_asks + 1;
				if ($urandom_range(0, 19) == 0)
					key_pool[$urandom_range(0, pool_n - 1)] = fresh_key();
				if ($urandom_range(0, 9) == 0)
					k = fresh_key();
				else
					k = key_pool[$urandom_range(0, pool_n - 1)];
				op = $urandom_range(0, 1) ? KIND_PUT : KIND_GET;
				send_request(op, k, $urandom, pick_gap());
			end
		end

		settle();
		sb.flush_leftovers();

		$display("covered %0d requests: %0d gets, %0d puts, %0d hits, %0d evictions",
			sb.gets + sb.puts, sb.gets, sb.puts, sb.hits, sb.evictions);
		$display("effective capacity %0d, %0d responses checked, %0d request stall cycles",
			cap_eff, sb.checked, input_stalls);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
